/* src/jsiq_pkg.sv */
package jsiq_pkg;

   localparam int OPCODE_W = 3;
   localparam int HANDLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int KEY_W    = TIME_W + 1;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [HANDLE_W-1:0] job_handle;
      logic [TIME_W-1:0]   submit_time;
      logic [TIME_W-1:0]   start_time;
      logic [POS_W-1:0]    position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] out_handle;
      logic [TIME_W-1:0]   out_submit;
      logic [TIME_W-1:0]   out_start;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   submit;
      logic [TIME_W-1:0]   start;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_PRE,
      ST_SHIFT,
      ST_PUT,
      ST_POP_CAP,
      ST_POP_SH,
      ST_READ_CAP,
      ST_RESP
   } state_type;

endpackage

/* src/jsiq_mem.sv */
module jsiq_mem #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  jsiq_pkg::slot_type wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output jsiq_pkg::slot_type rd_data
);
   import jsiq_pkg::*;

   slot_type mem_ff [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/jsiq_keycmp.sv */
module jsiq_keycmp (
   input  jsiq_pkg::slot_type cand_job,
   input  jsiq_pkg::slot_type stored_job,
   output logic               cand_gt
);
   import jsiq_pkg::*;

   logic [KEY_W-1:0] cand_key;
   logic [KEY_W-1:0] stored_key;

   // full-width key, no wrap
   assign cand_key   = {1'b0, cand_job.submit} + {1'b0, cand_job.start};
   assign stored_key = {1'b0, stored_job.submit} + {1'b0, stored_job.start};
   assign cand_gt    = cand_key > stored_key;

endmodule

/* src/job_sorted_insert_queue.sv */
// insert scans for its place, shifts later slots up where needed and writes the job; append
// writes at the tail; pop takes the head and shifts the rest down; read-at takes one slot;
// clear, unused opcodes and rejects go straight to the result, held while the last one stalls
// throughput: one operation at a time, the next beat is taken in the cycle after the result is loaded;
// the slot memory port and the single key comparator walk the queue one slot per cycle
// reset: synchronous, clears the count, sequencer and output valid; slot memory is not cleared
module job_sorted_insert_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jsiq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jsiq_pkg::rsp_type rsp_data
);
   import jsiq_pkg::*;

   localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     put_ff, put_in;
   req_type           job_ff, job_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   slot_type          res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              mem_we;
   logic [IW-1:0]     mem_waddr;
   slot_type          mem_wdata;
   logic [IW-1:0]     mem_raddr;
   slot_type          mem_rdata;
   slot_type          job_slot;
   logic              key_gt;

   logic              accept;
   logic              out_free;
   logic              cnt_full;
   logic              pos_ok;
   logic [CW-1:0]     idx_nx;
   logic [CW-1:0]     idx_dec;
   logic [CW-1:0]     idx_dec2;
   logic [CW-1:0]     cnt_dec;
   logic [CW-1:0]     cnt_inc;
   logic [IW+POS_W-1:0] pos_wide;
   logic [CW+OCC_W-1:0] cnt_wide;

   jsiq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   jsiq_keycmp u_keycmp (
      .cand_job   (job_slot),
      .stored_job (mem_rdata),
      .cand_gt    (key_gt)
   );

   assign job_slot = '{handle: job_ff.job_handle, submit: job_ff.submit_time,
                       start: job_ff.start_time};

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_full = cnt_ff == CW'(QUEUE_DEPTH);
   assign pos_ok   = CMPW'(req_data.position) < CMPW'(cnt_ff);
   assign idx_nx   = idx_ff + CW'(1);
   assign idx_dec  = idx_ff - CW'(1);
   assign idx_dec2 = idx_ff - CW'(2);
   assign cnt_dec  = cnt_ff - CW'(1);
   assign cnt_inc  = cnt_ff + CW'(1);
   assign pos_wide = {{IW{1'b0}}, req_data.position};
   assign cnt_wide = {{OCC_W{1'b0}}, cnt_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if (cnt_full) begin
                        state_in = ST_RESP;
                     end else if (cnt_ff == '0) begin
                        state_in = ST_PUT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_APPEND: state_in = cnt_full ? ST_RESP : ST_PUT;
                  OP_POP:    state_in = (cnt_ff == '0) ? ST_RESP : ST_POP_CAP;
                  OP_READ:   state_in = pos_ok ? ST_READ_CAP : ST_RESP;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (!key_gt) begin
               state_in = ST_SHIFT_PRE;
            end else if (idx_nx == cnt_ff) begin
               state_in = ST_PUT;
            end
         end
         ST_SHIFT_PRE: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (idx_dec == CW'(put_ff)) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: state_in = ST_RESP;
         ST_POP_CAP: begin
            state_in = (cnt_ff == CW'(1)) ? ST_RESP : ST_POP_SH;
         end
         ST_POP_SH: begin
            if (idx_nx == cnt_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_READ_CAP: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = 1'b1;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      put_in       = put_ff;
      job_in       = job_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = put_ff;
      mem_wdata    = job_slot;
      mem_raddr    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            // head is read ahead for pop and scan
            mem_raddr = (req_data.opcode == OP_READ) ? pos_wide[IW-1:0] : '0;
            if (accept) begin
               job_in    = req_data;
               status_in = STAT_OK;
               res_in    = '0;
               idx_in    = '0;
               put_in    = cnt_ff[IW-1:0];
               unique case (req_data.opcode)
                  OP_INSERT, OP_APPEND: begin
                     if (cnt_full) begin
                        status_in = STAT_FULL;
                     end
                  end
                  OP_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end
                  end
                  OP_READ: begin
                     if (!pos_ok) begin
                        status_in = STAT_EMPTY;
                     end
                  end
                  OP_CLEAR: cnt_in = '0;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            mem_raddr = idx_nx[IW-1:0];
            if (key_gt) begin
               idx_in = idx_nx;
               put_in = cnt_ff[IW-1:0];
            end else begin
               put_in = idx_ff[IW-1:0];
            end
         end
         ST_SHIFT_PRE: begin
            mem_raddr = cnt_dec[IW-1:0];
            idx_in    = cnt_ff;
         end
         ST_SHIFT: begin
            // slot idx-1 moves up to idx, fetch idx-2 for the next step
            mem_we    = 1'b1;
            mem_waddr = idx_ff[IW-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = idx_dec2[IW-1:0];
            idx_in    = idx_dec;
         end
         ST_PUT: begin
            mem_we = 1'b1;
            cnt_in = cnt_inc;
         end
         ST_POP_CAP: begin
            res_in    = mem_rdata;
            mem_raddr = idx_nx[IW-1:0];
            idx_in    = idx_nx;
            if (cnt_ff == CW'(1)) begin
               cnt_in = cnt_dec;
            end
         end
         ST_POP_SH: begin
            mem_we    = 1'b1;
            mem_waddr = idx_dec[IW-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = idx_nx[IW-1:0];
            idx_in    = idx_nx;
            if (idx_nx == cnt_ff) begin
               cnt_in = cnt_dec;
            end
         end
         ST_READ_CAP: res_in = mem_rdata;
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.out_handle = res_ff.handle;
               rsp_data_in.out_submit = res_ff.submit;
               rsp_data_in.out_start  = res_ff.start;
               rsp_data_in.occupancy  = cnt_wide[OCC_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      put_ff      <= put_in;
      job_ff      <= job_in;
      status_ff   <= status_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("job count above queue depth");

   a_cnt_origin: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         ($past(state_ff) == ST_PUT || $past(state_ff) == ST_POP_CAP ||
          $past(state_ff) == ST_POP_SH || $past(state_ff) == ST_IDLE ||
          $past(reset)))
      else $error("job count changed outside put, pop or clear");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("result raised outside response state");

endmodule
